>>> rtl/tsps_pkg.sv
`default_nettype none
package tsps_pkg;

  localparam int unsigned MAX_SEG_POINTS = 32;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned COORD_W        = 32;
  localparam int unsigned SPACING_W      = 31;
  localparam int unsigned NP_W           = 6;

  localparam logic [SPACING_W-1:0] SPACING_RESET = 31'd65536;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_FEW  = 2'd1,
    ST_OVER_CAP = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_ACC,
    OP_SQRT_START,
    OP_SQRT_STORE,
    OP_CEIL_START,
    OP_CEIL_STORE,
    OP_UNIT_START,
    OP_UNIT_STORE,
    OP_STEP_ROUND,
    OP_SEG_INIT,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    PK_FIRST,
    PK_INNER,
    PK_LAST,
    PK_ERROR
  } pkind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_CHK_ZERO,
    S_CEIL_GO,
    S_CEIL_WAIT,
    S_CHK_OVER,
    S_SEG_START,
    S_UNIT_GO,
    S_UNIT_WAIT,
    S_ROUND,
    S_SEG_INIT,
    S_EMIT,
    S_ERR
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    op_e        op;
    logic       seg;
    logic [1:0] comp;
    pkind_e     kind;
    status_e    status;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic            busy;
    logic            out_free;
    logic            spacing_zero;
    logic [1:0]      len_zero;
    logic [1:0]      over;
    logic [NP_W-1:0] np0;
    logic [NP_W-1:0] np1;
  } stat_t;

  typedef struct packed {
    point_t  pt;
    logic    segment_sel;
    status_e status;
    logic    last_point;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/tsps_in_if.sv
`default_nettype none
interface tsps_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_x;
  logic [31:0] start_y;
  logic [31:0] start_z;
  logic [31:0] corner_x;
  logic [31:0] corner_y;
  logic [31:0] corner_z;
  logic [31:0] finish_x;
  logic [31:0] finish_y;
  logic [31:0] finish_z;

  modport source (output valid, start_x, start_y, start_z, corner_x, corner_y, corner_z,
                  finish_x, finish_y, finish_z, input ready);
  modport sink (input valid, start_x, start_y, start_z, corner_x, corner_y, corner_z,
                finish_x, finish_y, finish_z, output ready);
endinterface
`default_nettype wire

>>> rtl/tsps_out_if.sv
`default_nettype none
interface tsps_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;
  logic        segment_sel;
  logic [1:0]  status;
  logic        last_point;

  modport source (output valid, point_x, point_y, point_z, segment_sel, status, last_point,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, segment_sel, status, last_point,
                output ready);
endinterface
`default_nettype wire

>>> rtl/tsps_dpath.sv
`default_nettype none
module tsps_dpath #(
  parameter int unsigned MAX_SEG_POINTS = tsps_pkg::MAX_SEG_POINTS,
  parameter int unsigned FRAC_BITS      = tsps_pkg::FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tsps_pkg::cmd_t                     cmd_i,
  input  tsps_pkg::point_t                   start_i,
  input  tsps_pkg::point_t                   corner_i,
  input  tsps_pkg::point_t                   finish_i,
  input  logic                               cfg_we_i,
  input  logic [tsps_pkg::SPACING_W-1:0]     cfg_wdata_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output tsps_pkg::result_t                  out_o,
  output tsps_pkg::stat_t                    stat_o
);

  localparam int unsigned CW       = tsps_pkg::COORD_W;
  localparam int unsigned SPW      = tsps_pkg::SPACING_W;
  localparam int unsigned NP_W     = tsps_pkg::NP_W;
  localparam int unsigned MAG_W    = CW + 1;
  localparam int unsigned SQ_W     = 2 * MAG_W;
  localparam int unsigned ROOT_W   = SQ_W / 2;
  localparam int unsigned REM_W    = ROOT_W + 4;
  localparam int unsigned NUM_W    = MAG_W + FRAC_BITS + 1;
  localparam int unsigned DEN_W    = ROOT_W;
  localparam int unsigned U_W      = FRAC_BITS + 1;
  localparam int unsigned PROD_W   = U_W + SPW;
  localparam int unsigned RND_W    = PROD_W + 1 - FRAC_BITS;
  localparam int unsigned STEP_W   = CW + 2;
  localparam int unsigned CUR_W    = CW + 8;
  localparam int unsigned SQ_ITERS = SQ_W / 2;
  localparam int unsigned CNT_W    = $clog2(NUM_W + 1);

  localparam logic signed [CUR_W-1:0] SAT_MAX = CUR_W'(64'sd2147483647);
  localparam logic signed [CUR_W-1:0] SAT_MIN = -CUR_W'(64'sd2147483648);

  function automatic logic signed [CW-1:0] comp_of(tsps_pkg::point_t p, logic [1:0] c);
    logic signed [CW-1:0] r;
    case (c)
      2'd0:    r = p.x;
      2'd1:    r = p.y;
      default: r = p.z;
    endcase
    return r;
  endfunction

  tsps_pkg::point_t      pts_q [3];
  logic [SPW-1:0]        spacing_q;
  logic [SQ_W-1:0]       acc_q;
  logic [ROOT_W-1:0]     len_q [2];
  logic [SQ_W-1:0]       rad_q;
  logic [REM_W-1:0]      srem_q;
  logic [ROOT_W-1:0]     root_q;
  logic [NUM_W-1:0]      num_q;
  logic [DEN_W-1:0]      den_q;
  logic [DEN_W-1:0]      drem_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  mode_q;
  logic [1:0]            over_q;
  logic [NP_W-1:0]       np_q [2];
  logic [PROD_W-1:0]     prod_q [3];
  logic signed [STEP_W-1:0] step_q [3];
  logic signed [CUR_W-1:0]  cur_q [3];
  logic                  out_valid_q;
  tsps_pkg::result_t     out_q;

  tsps_pkg::point_t      origin;
  tsps_pkg::point_t      dest;
  logic signed [MAG_W-1:0] diff [3];
  logic [MAG_W-1:0]      mag [3];
  logic [MAG_W-1:0]      mag_sel;
  logic [ROOT_W-1:0]     len_sel;
  logic [SQ_W-1:0]       sq;
  logic [REM_W-1:0]      srem_sh;
  logic [REM_W-1:0]      trial;
  logic                  sge;
  logic [DEN_W:0]        drem_sh;
  logic                  dge;
  logic signed [CUR_W-1:0] nxt [3];
  logic signed [CW-1:0]  sat [3];
  logic [RND_W:0]        rnd [3];
  logic signed [STEP_W-1:0] step_new [3];
  logic                  out_free;

  always_comb begin
    origin  = cmd_i.seg ? pts_q[1] : pts_q[0];
    dest    = cmd_i.seg ? pts_q[2] : pts_q[1];
    len_sel = len_q[cmd_i.seg];
    for (int c = 0; c < 3; c++) begin
      diff[c] = MAG_W'(comp_of(dest, 2'(c))) - MAG_W'(comp_of(origin, 2'(c)));
      mag[c]  = diff[c][MAG_W-1] ? MAG_W'(-diff[c]) : MAG_W'(diff[c]);
      nxt[c]  = cur_q[c] + CUR_W'(step_q[c]);
      if (nxt[c] > SAT_MAX) begin
        sat[c] = CW'(SAT_MAX);
      end else if (nxt[c] < SAT_MIN) begin
        sat[c] = CW'(SAT_MIN);
      end else begin
        sat[c] = CW'(nxt[c]);
      end
      rnd[c] = {2'b00, prod_q[c][PROD_W-1:FRAC_BITS]}
             + (RND_W + 1)'(prod_q[c][FRAC_BITS-1]);
      step_new[c] = diff[c][MAG_W-1] ? -STEP_W'(rnd[c]) : STEP_W'(rnd[c]);
    end
    mag_sel = mag[cmd_i.comp];
    sq      = SQ_W'(mag_sel) * SQ_W'(mag_sel);
    srem_sh = {srem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
    trial   = REM_W'({root_q, 2'b01});
    sge     = srem_sh >= trial;
    drem_sh = {drem_q, num_q[NUM_W-1]};
    dge     = drem_sh >= {1'b0, den_q};
    out_free = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q   <= tsps_pkg::SPACING_RESET;
      cnt_q       <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        spacing_q <= cfg_wdata_i;
      end
      if (cmd_i.op == tsps_pkg::OP_SQRT_START) begin
        cnt_q  <= CNT_W'(SQ_ITERS);
        mode_q <= 1'b0;
      end else if (cmd_i.op == tsps_pkg::OP_CEIL_START ||
                   cmd_i.op == tsps_pkg::OP_UNIT_START) begin
        cnt_q  <= CNT_W'(NUM_W);
        mode_q <= 1'b1;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.op == tsps_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_q != '0) begin
      if (!mode_q) begin
        rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
        srem_q <= sge ? srem_sh - trial : srem_sh;
        root_q <= {root_q[ROOT_W-2:0], sge};
      end else begin
        drem_q <= dge ? DEN_W'(drem_sh - {1'b0, den_q}) : drem_sh[DEN_W-1:0];
        num_q  <= {num_q[NUM_W-2:0], dge};
      end
    end
    case (cmd_i.op)
      tsps_pkg::OP_LOAD: begin
        pts_q[0] <= start_i;
        pts_q[1] <= corner_i;
        pts_q[2] <= finish_i;
      end
      tsps_pkg::OP_SQ_ACC: begin
        acc_q <= (cmd_i.comp == 2'd0) ? sq : acc_q + sq;
      end
      tsps_pkg::OP_SQRT_START: begin
        rad_q  <= acc_q;
        srem_q <= '0;
        root_q <= '0;
      end
      tsps_pkg::OP_SQRT_STORE: begin
        len_q[cmd_i.seg] <= root_q;
      end
      tsps_pkg::OP_CEIL_START: begin
        num_q  <= NUM_W'(len_sel) + NUM_W'(spacing_q) - NUM_W'(1);
        den_q  <= DEN_W'(spacing_q);
        drem_q <= '0;
      end
      tsps_pkg::OP_CEIL_STORE: begin
        over_q[cmd_i.seg] <= num_q >= NUM_W'(MAX_SEG_POINTS);
        np_q[cmd_i.seg]   <= NP_W'(num_q) + NP_W'(1);
      end
      tsps_pkg::OP_UNIT_START: begin
        num_q  <= (NUM_W'(mag_sel) << FRAC_BITS) + NUM_W'(len_sel >> 1);
        den_q  <= len_sel;
        drem_q <= '0;
      end
      tsps_pkg::OP_UNIT_STORE: begin
        prod_q[cmd_i.comp] <= PROD_W'(num_q[U_W-1:0]) * PROD_W'(spacing_q);
      end
      tsps_pkg::OP_STEP_ROUND: begin
        for (int c = 0; c < 3; c++) begin
          step_q[c] <= step_new[c];
        end
      end
      tsps_pkg::OP_SEG_INIT: begin
        for (int c = 0; c < 3; c++) begin
          cur_q[c] <= CUR_W'(comp_of(origin, 2'(c)));
        end
      end
      tsps_pkg::OP_EMIT: begin
        out_q.segment_sel <= cmd_i.seg;
        out_q.status      <= cmd_i.status;
        out_q.last_point  <= cmd_i.last;
        case (cmd_i.kind)
          tsps_pkg::PK_FIRST: out_q.pt <= origin;
          tsps_pkg::PK_LAST:  out_q.pt <= dest;
          tsps_pkg::PK_INNER: begin
            out_q.pt <= '{x: sat[0], y: sat[1], z: sat[2]};
            for (int c = 0; c < 3; c++) begin
              cur_q[c] <= nxt[c];
            end
          end
          default: out_q.pt <= '0;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    stat_o.busy         = cnt_q != '0;
    stat_o.out_free     = out_free;
    stat_o.spacing_zero = spacing_q == '0;
    stat_o.len_zero     = {len_q[1] == '0, len_q[0] == '0};
    stat_o.over         = over_q;
    stat_o.np0          = np_q[0];
    stat_o.np1          = np_q[1];
  end

endmodule
`default_nettype wire

>>> rtl/tsps_ctrl.sv
`default_nettype none
module tsps_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tsps_pkg::stat_t stat_i,
  output tsps_pkg::cmd_t  cmd_o
);

  localparam int unsigned NP_W = tsps_pkg::NP_W;

  tsps_pkg::state_e  state_q, state_d;
  logic              seg_q, seg_d;
  logic [1:0]        comp_q, comp_d;
  logic [NP_W-1:0]   idx_q, idx_d;
  tsps_pkg::status_e err_q, err_d;
  logic              esel_q, esel_d;
  logic [NP_W-1:0]   np_cur;
  logic              at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsps_pkg::S_IDLE;
      seg_q   <= 1'b0;
      comp_q  <= '0;
      idx_q   <= '0;
      err_q   <= tsps_pkg::ST_OK;
      esel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      seg_q   <= seg_d;
      comp_q  <= comp_d;
      idx_q   <= idx_d;
      err_q   <= err_d;
      esel_q  <= esel_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    seg_d      = seg_q;
    comp_d     = comp_q;
    idx_d      = idx_q;
    err_d      = err_q;
    esel_d     = esel_q;
    in_ready_o = 1'b0;
    np_cur     = seg_q ? stat_i.np1 : stat_i.np0;
    at_last    = idx_q == np_cur - NP_W'(1);
    cmd_o      = '{op: tsps_pkg::OP_NONE, seg: seg_q, comp: comp_q,
                   kind: tsps_pkg::PK_FIRST, status: tsps_pkg::ST_OK, last: 1'b0};
    case (state_q)
      tsps_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = tsps_pkg::OP_LOAD;
          seg_d    = 1'b0;
          comp_d   = '0;
          state_d  = tsps_pkg::S_SQ;
        end
      end
      tsps_pkg::S_SQ: begin
        cmd_o.op = tsps_pkg::OP_SQ_ACC;
        comp_d   = comp_q + 2'd1;
        if (comp_q == 2'd2) begin
          state_d = tsps_pkg::S_SQRT_GO;
        end
      end
      tsps_pkg::S_SQRT_GO: begin
        cmd_o.op = tsps_pkg::OP_SQRT_START;
        state_d  = tsps_pkg::S_SQRT_WAIT;
      end
      tsps_pkg::S_SQRT_WAIT: begin
        if (!stat_i.busy) begin
          cmd_o.op = tsps_pkg::OP_SQRT_STORE;
          if (!seg_q) begin
            seg_d   = 1'b1;
            comp_d  = '0;
            state_d = tsps_pkg::S_SQ;
          end else begin
            state_d = tsps_pkg::S_CHK_ZERO;
          end
        end
      end
      tsps_pkg::S_CHK_ZERO: begin
        if (stat_i.spacing_zero || (stat_i.len_zero == 2'b11)) begin
          err_d   = tsps_pkg::ST_TOO_FEW;
          esel_d  = 1'b0;
          state_d = tsps_pkg::S_ERR;
        end else begin
          seg_d   = 1'b0;
          state_d = tsps_pkg::S_CEIL_GO;
        end
      end
      tsps_pkg::S_CEIL_GO: begin
        cmd_o.op = tsps_pkg::OP_CEIL_START;
        state_d  = tsps_pkg::S_CEIL_WAIT;
      end
      tsps_pkg::S_CEIL_WAIT: begin
        if (!stat_i.busy) begin
          cmd_o.op = tsps_pkg::OP_CEIL_STORE;
          if (!seg_q) begin
            seg_d   = 1'b1;
            state_d = tsps_pkg::S_CEIL_GO;
          end else begin
            state_d = tsps_pkg::S_CHK_OVER;
          end
        end
      end
      tsps_pkg::S_CHK_OVER: begin
        if (stat_i.over != 2'b00) begin
          err_d   = tsps_pkg::ST_OVER_CAP;
          esel_d  = !stat_i.over[0];
          state_d = tsps_pkg::S_ERR;
        end else begin
          seg_d   = 1'b0;
          state_d = tsps_pkg::S_SEG_START;
        end
      end
      tsps_pkg::S_SEG_START: begin
        comp_d = '0;
        if (np_cur > NP_W'(2)) begin
          state_d = tsps_pkg::S_UNIT_GO;
        end else begin
          state_d = tsps_pkg::S_SEG_INIT;
        end
      end
      tsps_pkg::S_UNIT_GO: begin
        cmd_o.op = tsps_pkg::OP_UNIT_START;
        state_d  = tsps_pkg::S_UNIT_WAIT;
      end
      tsps_pkg::S_UNIT_WAIT: begin
        if (!stat_i.busy) begin
          cmd_o.op = tsps_pkg::OP_UNIT_STORE;
          comp_d   = comp_q + 2'd1;
          state_d  = (comp_q == 2'd2) ? tsps_pkg::S_ROUND : tsps_pkg::S_UNIT_GO;
        end
      end
      tsps_pkg::S_ROUND: begin
        cmd_o.op = tsps_pkg::OP_STEP_ROUND;
        state_d  = tsps_pkg::S_SEG_INIT;
      end
      tsps_pkg::S_SEG_INIT: begin
        cmd_o.op = tsps_pkg::OP_SEG_INIT;
        idx_d    = '0;
        state_d  = tsps_pkg::S_EMIT;
      end
      tsps_pkg::S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op   = tsps_pkg::OP_EMIT;
          cmd_o.last = at_last && seg_q;
          if (at_last) begin
            cmd_o.kind = tsps_pkg::PK_LAST;
          end else if (idx_q == '0) begin
            cmd_o.kind = tsps_pkg::PK_FIRST;
          end else begin
            cmd_o.kind = tsps_pkg::PK_INNER;
          end
          idx_d = idx_q + NP_W'(1);
          if (at_last) begin
            if (!seg_q) begin
              seg_d   = 1'b1;
              state_d = tsps_pkg::S_SEG_START;
            end else begin
              state_d = tsps_pkg::S_IDLE;
            end
          end
        end
      end
      tsps_pkg::S_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.op     = tsps_pkg::OP_EMIT;
          cmd_o.kind   = tsps_pkg::PK_ERROR;
          cmd_o.seg    = esel_q;
          cmd_o.status = err_q;
          cmd_o.last   = 1'b1;
          state_d      = tsps_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tsps_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/two_segment_point_sampler.sv
// Order: both segment lengths, both point-count divides, then for each segment with inner
// points three unit divides; a root takes SQ = COORD_W+1 steps and a divide N = FRAC_BITS+34
// steps on the shared radix-4 root and radix-2 divider. Error beats come earlier.
// Throughput: one item at a time; beats leave one per cycle within a segment while out ready
// is high, with setup between segments; the next item is taken while the final beat waits.
// Reset: asynchronous, active low; clears control state and sets point_spacing to 1.0.
`default_nettype none
module two_segment_point_sampler #(
  parameter int unsigned MAX_SEG_POINTS = tsps_pkg::MAX_SEG_POINTS,
  parameter int unsigned FRAC_BITS      = tsps_pkg::FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tsps_pkg::SPACING_W-1:0] cfg_wdata_i,
  tsps_in_if.sink                        in_i,
  tsps_out_if.source                     out_o
);

  tsps_pkg::cmd_t    cmd;
  tsps_pkg::stat_t   stat;
  tsps_pkg::result_t res;
  tsps_pkg::point_t  start_pt;
  tsps_pkg::point_t  corner_pt;
  tsps_pkg::point_t  finish_pt;
  logic              in_ready;
  logic              out_valid;

  assign start_pt  = '{x: in_i.start_x, y: in_i.start_y, z: in_i.start_z};
  assign corner_pt = '{x: in_i.corner_x, y: in_i.corner_y, z: in_i.corner_z};
  assign finish_pt = '{x: in_i.finish_x, y: in_i.finish_y, z: in_i.finish_z};
  assign in_i.ready = in_ready;

  tsps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tsps_dpath #(
    .MAX_SEG_POINTS (MAX_SEG_POINTS),
    .FRAC_BITS      (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .start_i     (start_pt),
    .corner_i    (corner_pt),
    .finish_i    (finish_pt),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_o       (res),
    .stat_o      (stat)
  );

  assign out_o.valid       = out_valid;
  assign out_o.point_x     = res.pt.x;
  assign out_o.point_y     = res.pt.y;
  assign out_o.point_z     = res.pt.z;
  assign out_o.segment_sel = res.segment_sel;
  assign out_o.status      = res.status;
  assign out_o.last_point  = res.last_point;

endmodule
`default_nettype wire
